>>> hdl/amst_pkg.sv
// Package for the affine matrix stack: operation codes, sizes, CORDIC table,
// fixed-point helpers. No dependencies.
package amst_pkg;

  localparam int StackDepth  = 64;
  localparam int CordicSteps = 16;
  localparam int LvlW        = $clog2(StackDepth);
  localparam int AddrW       = $clog2(StackDepth * 8);

  localparam logic [3:0] OP_IDENT     = 4'd0;
  localparam logic [3:0] OP_TRANSLATE = 4'd1;
  localparam logic [3:0] OP_SCALE     = 4'd2;
  localparam logic [3:0] OP_ROTATE    = 4'd3;
  localparam logic [3:0] OP_PUSH      = 4'd4;
  localparam logic [3:0] OP_POP       = 4'd5;
  localparam logic [3:0] OP_SET       = 4'd6;
  localparam logic [3:0] OP_COMPOSE   = 4'd7;
  localparam logic [3:0] OP_XFORM     = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PUSHFULL = 2'd1;
  localparam logic [1:0] ST_POPBOT   = 2'd2;

  localparam logic signed [31:0] TwoPi   = 32'sd411775;
  localparam logic signed [31:0] Pi      = 32'sd205887;
  localparam logic signed [31:0] HalfPi  = 32'sd102944;
  localparam logic signed [33:0] CordicK = 34'sd652032874;
  localparam logic signed [31:0] One     = 32'sd65536;

  // floor(2^50 / 2pi): quotient estimate is exact or one low
  localparam logic [31:0] TwoPiRecip = 32'((64'd1 << 50) / 64'd411775);

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      default: v = 34'sd1073741824 >>> i;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7fffffff;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  typedef struct packed {
    logic        ld_op;
    logic        cordic_go;
    logic        mul_go;
    logic [2:0]  term;
  } amst_cmd_t;

endpackage

>>> hdl/amst_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module amst_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/amst_cordic.sv
// Iterative CORDIC sine/cosine unit, one rotation per cycle, plus angle reduction.
// Depends on amst_pkg.
module amst_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);
  typedef enum logic [2:0] {C_IDLE, C_MUL, C_QM, C_FIX, C_RED, C_RUN, C_FIN} cst_t;
  cst_t cst_r;
  logic neg_r;
  logic [31:0] mag_r, rm_r;
  logic [13:0] q_r;
  logic signed [31:0] rem_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic [4:0] i_r;
  logic flip_r;
  logic [31:0] rf;
  logic signed [31:0] r1, r2;
  logic signed [33:0] xr, yr;

  always_comb begin
    rf = (rm_r >= 32'(amst_pkg::TwoPi)) ? rm_r - 32'(amst_pkg::TwoPi) : rm_r;
    r1 = rem_r;
    if (r1 > amst_pkg::Pi) r1 = r1 - amst_pkg::TwoPi;
    if (r1 < -amst_pkg::Pi) r1 = r1 + amst_pkg::TwoPi;
    r2 = r1;
    if (r1 > amst_pkg::HalfPi) r2 = r1 - amst_pkg::Pi;
    else if (r1 < -amst_pkg::HalfPi) r2 = r1 + amst_pkg::Pi;
    xr = (x_r + 34'sd8192) >>> 14;
    yr = (y_r + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (cst_r == C_FIN);
      case (cst_r)
        C_IDLE: if (start) begin
          neg_r <= angle[31];
          mag_r <= angle[31] ? 32'(-angle) : 32'(angle);
          cst_r <= C_MUL;
        end
        C_MUL: begin
          q_r   <= 14'((64'(mag_r) * 64'(amst_pkg::TwoPiRecip)) >> 50);
          cst_r <= C_QM;
        end
        C_QM: begin
          rm_r  <= mag_r - 32'(q_r) * 32'(amst_pkg::TwoPi);
          cst_r <= C_FIX;
        end
        C_FIX: begin
          rem_r <= neg_r ? -$signed(rf) : $signed(rf);
          cst_r <= C_RED;
        end
        C_RED: begin
          flip_r <= (r1 > amst_pkg::HalfPi) || (r1 < -amst_pkg::HalfPi);
          z_r    <= {r2, 2'b00} <<< 12;
          x_r    <= amst_pkg::CordicK;
          y_r    <= '0;
          i_r    <= '0;
          cst_r  <= C_RUN;
        end
        C_RUN: begin
          if (!z_r[33]) begin
            x_r <= x_r - (y_r >>> i_r);
            y_r <= y_r + (x_r >>> i_r);
            z_r <= z_r - amst_pkg::atan_q30(i_r);
          end else begin
            x_r <= x_r + (y_r >>> i_r);
            y_r <= y_r - (x_r >>> i_r);
            z_r <= z_r + amst_pkg::atan_q30(i_r);
          end
          i_r <= i_r + 5'd1;
          if (i_r == 5'(amst_pkg::CordicSteps - 1)) cst_r <= C_FIN;
        end
        C_FIN: begin
          cos_q <= flip_r ? -xr[31:0] : xr[31:0];
          sin_q <= flip_r ? -yr[31:0] : yr[31:0];
          cst_r <= C_IDLE;
        end
        default: cst_r <= C_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/amst_ctrl.sv
// Controller FSM for the matrix stack: sequences fetch, compute, write-back, output.
// Depends on amst_pkg.
module amst_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            op,
  input  logic [1:0]            copies,
  input  logic                  cordic_done,
  output logic                  ld,
  output logic                  rd_go,
  output logic                  calc_go,
  output logic                  wb_go,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_last,
  output logic                  out_pt,
  output logic [1:0]            out_status,
  output logic                  cordic_go,
  output logic [amst_pkg::LvlW-1:0] lvl
);
  typedef enum logic [2:0] {S_IDLE, S_RD, S_CORD, S_CALC, S_WB, S_OUT} st_t;
  st_t st_r;
  logic [3:0] op_r;
  logic [1:0] cnt_r;
  logic [2:0] ph_r;

  assign in_ready  = (st_r == S_IDLE);
  assign ld        = in_valid && in_ready;
  assign rd_go     = (st_r == S_RD);
  assign calc_go   = (st_r == S_CALC);
  assign wb_go     = (st_r == S_WB);
  assign out_valid = (st_r == S_OUT);
  assign out_last  = (cnt_r == 2'd1);
  assign out_pt    = (op_r == amst_pkg::OP_XFORM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      lvl <= '0;
      cordic_go <= 1'b0;
      out_status <= amst_pkg::ST_OK;
      cnt_r <= 2'd1;
      op_r <= '0;
      ph_r <= '0;
    end else begin
      cordic_go <= (st_r == S_RD) && (ph_r == 3'd6) && (op_r == amst_pkg::OP_ROTATE);
      case (st_r)
        S_IDLE: if (ld) begin
          op_r <= op;
          cnt_r <= (op == amst_pkg::OP_XFORM && copies[1]) ? 2'd2 : 2'd1;
          out_status <= amst_pkg::ST_OK;
          ph_r <= '0;
          st_r <= S_RD;
        end
        S_RD: begin
          if (ph_r == 3'd6) begin
            ph_r <= '0;
            if (op_r == amst_pkg::OP_ROTATE) st_r <= S_CORD;
            else st_r <= S_CALC;
          end else ph_r <= ph_r + 3'd1;
        end
        S_CORD: if (cordic_done) st_r <= S_CALC;
        S_CALC: begin
          if (ph_r == 3'd6) begin
            ph_r <= '0;
            st_r <= S_WB;
          end else ph_r <= ph_r + 3'd1;
        end
        S_WB: begin
          ph_r <= ph_r + 3'd1;
          if (ph_r == 3'd5) begin
            st_r <= S_OUT;
            if (op_r == amst_pkg::OP_PUSH) begin
              if (lvl == amst_pkg::LvlW'(amst_pkg::StackDepth - 1))
                out_status <= amst_pkg::ST_PUSHFULL;
              else lvl <= lvl + 1'b1;
            end else if (op_r == amst_pkg::OP_POP) begin
              if (lvl == '0) out_status <= amst_pkg::ST_POPBOT;
              else lvl <= lvl - 1'b1;
            end
          end
        end
        S_OUT: if (out_ready) begin
          if (cnt_r == 2'd1) st_r <= S_IDLE;
          cnt_r <= cnt_r - 2'd1;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/amst_dp.sv
// Datapath: matrix RAM, working matrix, shared pair of 32x32 multipliers, six-entry compute.
// Depends on amst_pkg, amst_ram, amst_cordic.
module amst_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ld,
  input  logic                  rd_go,
  input  logic                  calc_go,
  input  logic                  wb_go,
  input  logic                  cordic_go,
  output logic                  cordic_done,
  input  logic [amst_pkg::LvlW-1:0] lvl,
  input  logic [3:0]            in_op,
  input  logic signed [31:0]    in_x, in_y, in_angle,
  input  logic signed [31:0]    in_m_a, in_m_b, in_m_c, in_m_d, in_m_e, in_m_f,
  output logic signed [31:0]    px,
  output logic signed [31:0]    py
);
  logic [3:0] op_r;
  logic signed [31:0] x_r, y_r, ang_r;
  logic signed [31:0] f_r [6];
  logic signed [31:0] m_r [6];
  logic signed [31:0] n_r [6];
  logic [2:0] rph_r, cph_r, wph_r;
  logic [7:0] z_r;
  logic we;
  logic [amst_pkg::AddrW-1:0] waddr, raddr;
  logic [31:0] rdata, wdata;
  logic signed [31:0] cs, sn;

  amst_cordic u_cordic (.clk, .rst_n, .start(cordic_go), .angle(ang_r),
                        .done(cordic_done), .cos_q(cs), .sin_q(sn));

  amst_ram #(.Width(32), .Depth(amst_pkg::StackDepth * 8)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata);

  // level-0 words zero until written: one written bit per word
  always_ff @(posedge clk) begin
    if (!rst_n) z_r <= '0;
    else if (we && waddr[amst_pkg::AddrW-1:3] == '0) z_r[waddr[2:0]] <= 1'b1;
  end

  logic [2:0] rsel;
  assign rsel  = rph_r;
  assign raddr = {lvl, rsel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rph_r <= '0; cph_r <= '0; wph_r <= '0;
    end else begin
      if (ld) begin
        op_r <= in_op; x_r <= in_x; y_r <= in_y; ang_r <= in_angle;
        f_r[0] <= in_m_a; f_r[1] <= in_m_b; f_r[2] <= in_m_c;
        f_r[3] <= in_m_d; f_r[4] <= in_m_e; f_r[5] <= in_m_f;
        rph_r <= '0; cph_r <= '0; wph_r <= '0;
      end
      if (rd_go) begin
        rph_r <= rph_r + 3'd1;
        if (rph_r != 3'd0) begin
          m_r[rph_r - 3'd1] <= (lvl == '0 && !z_r[rph_r - 3'd1]) ? '0 : rdata;
        end
      end
      if (calc_go) cph_r <= cph_r + 3'd1;
      if (wb_go) wph_r <= wph_r + 3'd1;
    end
  end

  // one two-product entry per cycle: p*q + r*s + t
  logic signed [31:0] p, q, r, s, t;
  logic use_t;
  always_comb begin
    p = '0; q = '0; r = '0; s = '0; t = '0; use_t = 1'b0;
    case (op_r)
      amst_pkg::OP_TRANSLATE, amst_pkg::OP_XFORM: begin
        case (cph_r)
          3'd2: begin p = m_r[0]; q = x_r; r = m_r[1]; s = y_r; t = m_r[2]; end
          3'd5: begin p = m_r[3]; q = x_r; r = m_r[4]; s = y_r; t = m_r[5]; end
          default: ;
        endcase
      end
      amst_pkg::OP_SCALE: begin
        case (cph_r)
          3'd0: begin p = m_r[0]; q = x_r; end
          3'd1: begin p = m_r[1]; q = y_r; end
          3'd3: begin p = m_r[3]; q = x_r; end
          3'd4: begin p = m_r[4]; q = y_r; end
          default: ;
        endcase
      end
      amst_pkg::OP_ROTATE: begin
        case (cph_r)
          3'd0: begin p = m_r[0]; q = cs; r = m_r[1]; s = sn; end
          3'd1: begin p = m_r[0]; q = -sn; r = m_r[1]; s = cs; end
          3'd3: begin p = m_r[3]; q = cs; r = m_r[4]; s = sn; end
          3'd4: begin p = m_r[3]; q = -sn; r = m_r[4]; s = cs; end
          default: ;
        endcase
      end
      amst_pkg::OP_COMPOSE: begin
        case (cph_r)
          3'd0: begin p = m_r[0]; q = f_r[0]; r = m_r[1]; s = f_r[3]; end
          3'd1: begin p = m_r[0]; q = f_r[1]; r = m_r[1]; s = f_r[4]; end
          3'd2: begin p = m_r[0]; q = f_r[2]; r = m_r[1]; s = f_r[5]; t = m_r[2]; end
          3'd3: begin p = m_r[3]; q = f_r[0]; r = m_r[4]; s = f_r[3]; end
          3'd4: begin p = m_r[3]; q = f_r[1]; r = m_r[4]; s = f_r[4]; end
          3'd5: begin p = m_r[3]; q = f_r[2]; r = m_r[4]; s = f_r[5]; t = m_r[5]; end
          default: ;
        endcase
      end
      default: ;
    endcase
    use_t = 1'b1;
  end

  logic signed [63:0] m1_r, m2_r;
  logic signed [31:0] t_r;
  logic [2:0] ci_r;
  logic cv_r;
  logic signed [49:0] hi;
  logic [17:0] lo;
  always_ff @(posedge clk) begin
    m1_r <= p * q;
    m2_r <= r * s;
    t_r  <= use_t ? t : '0;
    ci_r <= cph_r;
    cv_r <= calc_go && (cph_r < 3'd6);
  end
  always_comb begin
    lo = {2'b00, m1_r[15:0]} + {2'b00, m2_r[15:0]} + 18'h08000;
    hi = 50'($signed(m1_r[63:16])) + 50'($signed(m2_r[63:16])) + 50'(t_r)
         + 50'(lo[17:16]);
  end

  always_ff @(posedge clk) begin
    if (ld) for (int k = 0; k < 6; k++) n_r[k] <= '0;
    else if (calc_go && cph_r == 3'd0) for (int k = 0; k < 6; k++) n_r[k] <= m_r[k];
    else if (cv_r) begin
      case (op_r)
        amst_pkg::OP_TRANSLATE, amst_pkg::OP_COMPOSE, amst_pkg::OP_XFORM:
          if ((op_r == amst_pkg::OP_COMPOSE) || ci_r == 3'd2 || ci_r == 3'd5)
            n_r[ci_r] <= amst_pkg::sat32(hi);
        amst_pkg::OP_SCALE, amst_pkg::OP_ROTATE:
          if (ci_r != 3'd2 && ci_r != 3'd5) n_r[ci_r] <= amst_pkg::sat32(hi);
        default: ;
      endcase
    end
  end

  always_comb begin
    we = 1'b0; waddr = {lvl, wph_r}; wdata = n_r[wph_r];
    case (op_r)
      amst_pkg::OP_IDENT: begin
        we = wb_go;
        wdata = (wph_r == 3'd0 || wph_r == 3'd4) ? amst_pkg::One : '0;
      end
      amst_pkg::OP_SET: begin we = wb_go; wdata = f_r[wph_r]; end
      amst_pkg::OP_TRANSLATE, amst_pkg::OP_SCALE, amst_pkg::OP_ROTATE,
      amst_pkg::OP_COMPOSE: we = wb_go;
      amst_pkg::OP_PUSH: begin
        we = wb_go && (lvl != amst_pkg::LvlW'(amst_pkg::StackDepth - 1));
        waddr = {lvl + 1'b1, wph_r};
        wdata = m_r[wph_r];
      end
      default: ;
    endcase
  end

  assign px = n_r[2];
  assign py = n_r[5];
endmodule

>>> hdl/affine_matrix_stack_transform_top.sv
// Top level of the affine matrix stack transform.
// Depends on amst_pkg, amst_ctrl, amst_dp.
//
// Usage: one input beat carries an operation and its operands; the block
// answers with one result beat (status, zero point) or, for a point
// transform, one or two beats carrying the point, last set on the final one.
// Matrices live in a RAM of eight words per stack level; the current level
// is read out word by word, the six entries computed on one shared pair
// of 32x32 multipliers, then written back. Rotation adds angle reduction
// and the CORDIC unit: setup (quotient estimate, remainder, correction,
// quadrant fold), 16 iterations, then rounding and hand-back. Items are
// handled one at a time, in_ready is high only when idle, and the next
// input beat can be taken in the cycle after the last result beat. A
// stalled receiver holds the result beat stable and blocks further input.
// Reset (rst_n low, synchronous) clears the stack level to zero; level
// zero reads as the zero matrix until written.
module affine_matrix_stack_transform_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_operation,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_angle,
  input  logic signed [31:0] in_m_a,
  input  logic signed [31:0] in_m_b,
  input  logic signed [31:0] in_m_c,
  input  logic signed [31:0] in_m_d,
  input  logic signed [31:0] in_m_e,
  input  logic signed [31:0] in_m_f,
  input  logic [1:0]         in_copies,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [1:0]         out_status,
  output logic               out_last
);
  logic ld, rd_go, calc_go, wb_go, cordic_go, cordic_done, out_pt;
  logic [amst_pkg::LvlW-1:0] lvl;
  logic signed [31:0] px, py;

  amst_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .op(in_operation), .copies(in_copies),
    .cordic_done, .ld, .rd_go, .calc_go, .wb_go, .out_valid, .out_ready,
    .out_last, .out_pt, .out_status, .cordic_go, .lvl);

  amst_dp u_dp (
    .clk, .rst_n, .ld, .rd_go, .calc_go, .wb_go, .cordic_go, .cordic_done, .lvl,
    .in_op(in_operation), .in_x, .in_y, .in_angle, .in_m_a, .in_m_b, .in_m_c,
    .in_m_d, .in_m_e, .in_m_f, .px, .py);

  assign out_x = out_pt ? px : '0;
  assign out_y = out_pt ? py : '0;
endmodule
